FILE: src/bppd_pkg.sv
// Package for the bitplane palette pixel decoder.
// Holds the palette geometry, item and mode codes and the colour word decode.
// No dependencies; bppd_palette_ram and the top level use it.
package bppd_pkg;

    localparam int PAL_DEPTH = 16;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int RGB_W     = 24;

    // Item kinds carried in the func field.
    localparam logic [1:0] FUNC_SCREEN = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_ROTATE = 2'd2;

    // Resolution register codes. The last one has no screen output.
    localparam logic [1:0] RES_LOW  = 2'd0;
    localparam logic [1:0] RES_MED  = 2'd1;
    localparam logic [1:0] RES_HIGH = 2'd2;
    localparam logic [1:0] RES_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_RESOLUTION = 1'b0;
    localparam logic CFG_ENTRIES    = 1'b1;

    // Smallest palette that each indexed resolution needs.
    localparam logic [4:0] MIN_ENTRIES_LOW = 5'd16;
    localparam logic [4:0] MIN_ENTRIES_MED = 5'd4;

    localparam logic [4:0] ENTRIES_RESET = 5'd16;

    localparam logic [7:0] LEVEL_STEP = 8'd36;
    localparam logic [7:0] FINE_STEP  = 8'd3;

    typedef logic [RGB_W-1:0] rgb_t;

    function automatic logic [7:0] channel_value(input logic [2:0] level, input logic fine);
        logic [7:0] base;
        base = {5'd0, level} * LEVEL_STEP;
        return base + (fine ? FINE_STEP : 8'd0);
    endfunction

    // Red sits in the high byte, green and blue in the low byte.
    function automatic rgb_t decode_colour(input logic [15:0] word);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = channel_value(word[10:8], word[11]);
        g = channel_value(word[6:4], word[7]);
        b = channel_value(word[2:0], word[3]);
        return {r, g, b};
    endfunction

endpackage

FILE: src/bppd_cmd_if.sv
// Input channel of the bitplane palette pixel decoder: one command beat.
// Uses bppd_pkg for nothing but keeps the valid/ready handshake with payload.
interface bppd_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] plane_word_0;
    logic [15:0] plane_word_1;
    logic [15:0] plane_word_2;
    logic [15:0] plane_word_3;
    logic [3:0]  entry_index;
    logic [15:0] colour_word;
    logic [3:0]  rot_left;
    logic [3:0]  rot_right;

    modport source (
        output valid, func, plane_word_0, plane_word_1, plane_word_2, plane_word_3,
               entry_index, colour_word, rot_left, rot_right,
        input  ready
    );

    modport sink (
        input  valid, func, plane_word_0, plane_word_1, plane_word_2, plane_word_3,
               entry_index, colour_word, rot_left, rot_right,
        output ready
    );
endinterface

FILE: src/bppd_pixel_if.sv
// Output channel of the bitplane palette pixel decoder: one pixel beat.
// Standalone valid/ready interface with the pixel payload.
interface bppd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic       palette_error;

    modport source (
        output valid, red, green, blue, last_pixel, palette_error,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, last_pixel, palette_error,
        output ready
    );
endinterface

FILE: src/bppd_palette_ram.sv
// Palette memory: one write port and one read port, read data registered.
// Uses bppd_pkg for depth and entry width; entries never written read as black.
module bppd_palette_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bppd_pkg::PAL_AW-1:0] wr_addr,
    input  bppd_pkg::rgb_t              wr_data,
    input  logic [bppd_pkg::PAL_AW-1:0] rd_addr,
    output bppd_pkg::rgb_t              rd_data
);

    bppd_pkg::rgb_t                    mem [bppd_pkg::PAL_DEPTH];
    logic [bppd_pkg::PAL_DEPTH-1:0]    valid_reg;
    bppd_pkg::rgb_t                    rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-first: a read of the address being written returns the old entry.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/bitplane_palette_pixel_decoder.sv
// Top level of the bitplane palette pixel decoder.
// Depends on bppd_pkg, bppd_cmd_if, bppd_pixel_if and bppd_palette_ram.
//
// Usage:
// Commands arrive as beats on the cmd channel and pixels leave as beats on
// the pixel channel; both use valid/ready. Configuration is written through
// cfg_we, cfg_index and cfg_data while the block is idle.
// A screen command yields 16 pixel beats, most significant plane bit first,
// with last_pixel on the sixteenth; a palette that is too small for the
// resolution yields one error beat instead, and resolution three yields none.
// The command beat loads the plane registers; the pixel stage and the
// palette memory's read register take the first pixel, and the output
// register takes it from them. An error beat goes from the command beat
// straight into the pixel stage. After that one pixel leaves per cycle
// while the receiver is ready, through the memory's single read port.
// A palette write is done as its command beat is accepted. A rotate reads
// and rewrites one entry per cycle through the memory.
// One command is worked on at a time; cmd.ready is high only between them.
// Reset clears the palette to black, sets low resolution and 16 entries.
// When the receiver stalls, the output register holds its beat and the
// memory keeps re-reading the pending pixel, so nothing is lost.
module bitplane_palette_pixel_decoder (
    input  logic                clk,
    input  logic                rst_n,
    bppd_cmd_if.sink            cmd,
    bppd_pixel_if.source        pixel,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [4:0]          cfg_data
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PIX       = 3'd1;
    localparam logic [2:0] S_ROT_FIRST = 3'd2;
    localparam logic [2:0] S_ROT_SHIFT = 3'd3;
    localparam logic [2:0] S_ROT_LAST  = 3'd4;

    localparam int AW = bppd_pkg::PAL_AW;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  resolution_reg;
    logic [4:0]  entries_reg;

    // Plane shift registers; bit 15 is the next pixel.
    logic [15:0] plane0_reg, plane1_reg, plane2_reg, plane3_reg;
    logic [4:0]  left_reg, left_next;

    // Pixel stage whose palette read is in flight.
    logic          p1_valid_reg, p1_valid_next;
    logic          p1_last_reg, p1_err_reg, p1_mono_reg, p1_bit_reg, p1_inrange_reg;
    logic [AW-1:0] p1_addr_reg;

    // Rotate bookkeeping.
    logic [AW-1:0]   cur_reg, rot_left_reg;
    logic            rot_up_reg;
    bppd_pkg::rgb_t  moved_reg;

    logic            out_valid_reg;
    bppd_pkg::rgb_t  out_rgb_reg;
    logic            out_last_reg, out_err_reg;

    logic            accept;
    logic            pal_too_small;
    logic            cap;
    logic            advance;
    logic [3:0]      idx_now;
    logic            idx_inrange;
    logic [AW-1:0]   nbr, nbr2;
    logic            rot_ok;
    logic            wr_ok;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    bppd_pkg::rgb_t  ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    bppd_pkg::rgb_t  ram_rd_data;
    bppd_pkg::rgb_t  pix_rgb;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    assign pal_too_small =
        (resolution_reg == bppd_pkg::RES_LOW && entries_reg < bppd_pkg::MIN_ENTRIES_LOW) ||
        (resolution_reg == bppd_pkg::RES_MED && entries_reg < bppd_pkg::MIN_ENTRIES_MED);

    assign rot_ok = ({1'b0, cmd.rot_left}  < 5'(bppd_pkg::PAL_DEPTH)) &&
                    ({1'b0, cmd.rot_right} < 5'(bppd_pkg::PAL_DEPTH));
    assign wr_ok  = ({1'b0, cmd.entry_index} < 5'(bppd_pkg::PAL_DEPTH));

    // The output register takes a beat when it is empty or being drained.
    assign cap     = p1_valid_reg && (!out_valid_reg || pixel.ready);
    assign advance = !p1_valid_reg || cap;

    always_comb
    begin
        idx_now = {2'b00, plane1_reg[15], plane0_reg[15]};
        if (resolution_reg == bppd_pkg::RES_LOW)
        begin
            idx_now = {plane3_reg[15], plane2_reg[15], plane1_reg[15], plane0_reg[15]};
        end
    end

    assign idx_inrange = ({1'b0, idx_now} < 5'(bppd_pkg::PAL_DEPTH));

    assign nbr  = rot_up_reg ? cur_reg - AW'(1) : cur_reg + AW'(1);
    assign nbr2 = rot_up_reg ? nbr - AW'(1)     : nbr + AW'(1);

    always_comb
    begin
        case (state_reg)
            S_IDLE:      ram_rd_addr = cmd.rot_right[AW-1:0];
            S_PIX:       ram_rd_addr = advance ? idx_now[AW-1:0] : p1_addr_reg;
            S_ROT_FIRST: ram_rd_addr = nbr;
            S_ROT_SHIFT: ram_rd_addr = nbr2;
            default:     ram_rd_addr = '0;
        endcase
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_reg;
        ram_wr_data = ram_rd_data;
        case (state_reg)
            S_IDLE:
            begin
                ram_wr_en   = accept && cmd.func == bppd_pkg::FUNC_WRITE && wr_ok;
                ram_wr_addr = cmd.entry_index[AW-1:0];
                ram_wr_data = bppd_pkg::decode_colour(cmd.colour_word);
            end
            S_ROT_FIRST:
            begin
                // Equal indices: the entry is written back unchanged.
                ram_wr_en   = (cur_reg == rot_left_reg);
                ram_wr_addr = rot_left_reg;
            end
            S_ROT_SHIFT:
            begin
                ram_wr_en = 1'b1;
            end
            S_ROT_LAST:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = rot_left_reg;
                ram_wr_data = moved_reg;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    bppd_palette_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        left_next     = left_reg;
        p1_valid_next = p1_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == bppd_pkg::FUNC_SCREEN &&
                        resolution_reg != bppd_pkg::RES_NONE)
                    begin
                        state_next = S_PIX;
                        if (pal_too_small && resolution_reg != bppd_pkg::RES_HIGH)
                        begin
                            p1_valid_next = 1'b1;
                            left_next     = 5'd0;
                        end
                        else
                        begin
                            left_next = 5'd16;
                        end
                    end
                    else if (cmd.func == bppd_pkg::FUNC_ROTATE && rot_ok)
                    begin
                        state_next = S_ROT_FIRST;
                    end
                end
            end
            S_PIX:
            begin
                if (advance)
                begin
                    if (left_reg != 5'd0)
                    begin
                        p1_valid_next = 1'b1;
                        left_next     = left_reg - 5'd1;
                    end
                    else
                    begin
                        p1_valid_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_ROT_FIRST:
            begin
                state_next = (cur_reg == rot_left_reg) ? S_IDLE : S_ROT_SHIFT;
            end
            S_ROT_SHIFT:
            begin
                if (nbr == rot_left_reg)
                begin
                    state_next = S_ROT_LAST;
                end
            end
            S_ROT_LAST:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            left_reg       <= '0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            resolution_reg <= bppd_pkg::RES_LOW;
            entries_reg    <= bppd_pkg::ENTRIES_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            left_reg     <= left_next;
            p1_valid_reg <= p1_valid_next;
            if (cap)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == bppd_pkg::CFG_RESOLUTION)
                begin
                    resolution_reg <= cfg_data[1:0];
                end
                else
                begin
                    entries_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plane0_reg   <= cmd.plane_word_0;
            plane1_reg   <= cmd.plane_word_1;
            plane2_reg   <= cmd.plane_word_2;
            plane3_reg   <= cmd.plane_word_3;
            cur_reg      <= cmd.rot_right[AW-1:0];
            rot_left_reg <= cmd.rot_left[AW-1:0];
            rot_up_reg   <= (cmd.rot_right > cmd.rot_left);
            // The error beat goes straight into the pixel stage.
            p1_err_reg   <= 1'b1;
            p1_last_reg  <= 1'b1;
            p1_mono_reg  <= 1'b0;
            p1_bit_reg   <= 1'b0;
            p1_inrange_reg <= 1'b0;
        end
        else if (state_reg == S_PIX && advance && left_reg != 5'd0)
        begin
            plane0_reg     <= {plane0_reg[14:0], 1'b0};
            plane1_reg     <= {plane1_reg[14:0], 1'b0};
            plane2_reg     <= {plane2_reg[14:0], 1'b0};
            plane3_reg     <= {plane3_reg[14:0], 1'b0};
            p1_addr_reg    <= idx_now[AW-1:0];
            p1_err_reg     <= 1'b0;
            p1_last_reg    <= (left_reg == 5'd1);
            p1_mono_reg    <= (resolution_reg == bppd_pkg::RES_HIGH);
            p1_bit_reg     <= plane0_reg[15];
            p1_inrange_reg <= idx_inrange;
        end

        // The source index stays in cur_reg so the first shift overwrites it.
        if (state_reg == S_ROT_FIRST)
        begin
            moved_reg <= ram_rd_data;
        end
        else if (state_reg == S_ROT_SHIFT)
        begin
            cur_reg <= nbr;
        end
    end

    always_comb
    begin
        if (p1_err_reg)
        begin
            pix_rgb = '0;
        end
        else if (p1_mono_reg)
        begin
            pix_rgb = p1_bit_reg ? '1 : '0;
        end
        else
        begin
            pix_rgb = p1_inrange_reg ? ram_rd_data : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            out_rgb_reg  <= pix_rgb;
            out_last_reg <= p1_last_reg;
            out_err_reg  <= p1_err_reg;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.red           = out_rgb_reg[23:16];
    assign pixel.green         = out_rgb_reg[15:8];
    assign pixel.blue          = out_rgb_reg[7:0];
    assign pixel.last_pixel    = out_last_reg;
    assign pixel.palette_error = out_err_reg;

endmodule
